>>> design/gda_pkg.sv
`timescale 1ns / 1ps
// Package for the Gregorian date stepper: sequencer states, calendar constants
// and the month length function. No dependencies.
package gda_pkg;

    localparam int DEF_OFFSET_BITS = 21;
    localparam int DEF_YEAR_BITS   = 14;

    localparam int DAY_BITS   = 5;
    localparam int MONTH_BITS = 4;
    localparam int CNT_BITS   = 12;
    localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

    // Year residue modulo the 400-year Gregorian cycle.
    localparam int CYCLE_YEARS = 400;
    localparam int CYC_BITS    = 9;
    localparam logic [CYC_BITS-1:0] CYC_LAST = CYC_BITS'(CYCLE_YEARS - 1);
    localparam logic [CYC_BITS-1:0] CENT_1   = CYC_BITS'(100);
    localparam logic [CYC_BITS-1:0] CENT_2   = CYC_BITS'(200);
    localparam logic [CYC_BITS-1:0] CENT_3   = CYC_BITS'(300);

    localparam logic [MONTH_BITS-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_BITS-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_BITS-1:0] MON_MAR = 4'd3;
    localparam logic [MONTH_BITS-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_BITS-1:0] MON_JUN = 4'd6;
    localparam logic [MONTH_BITS-1:0] MON_SEP = 4'd9;
    localparam logic [MONTH_BITS-1:0] MON_NOV = 4'd11;
    localparam logic [MONTH_BITS-1:0] MON_DEC = 4'd12;

    localparam logic [DAY_BITS-1:0] DAY_FIRST = 5'd1;
    localparam logic [DAY_BITS-1:0] LEN_SHORT = 5'd28;
    localparam logic [DAY_BITS-1:0] LEN_LEAP  = 5'd29;
    localparam logic [DAY_BITS-1:0] LEN_30    = 5'd30;
    localparam logic [DAY_BITS-1:0] LEN_31    = 5'd31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_PREP,
        ST_WALK,
        ST_DONE
    } state_t;

    function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] m,
                                                      input logic leap);
        logic [DAY_BITS-1:0] len;
        if (m == MON_FEB) begin
            len = leap ? LEN_LEAP : LEN_SHORT;
        end
        else if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV) begin
            len = LEN_30;
        end
        else begin
            len = LEN_31;
        end
        return len;
    endfunction

    function automatic logic is_leap(input logic [CYC_BITS-1:0] r);
        return (r[1:0] == 2'b00) && (r != CENT_1) && (r != CENT_2) && (r != CENT_3);
    endfunction

endpackage

>>> design/gda_mod400.sv
`timescale 1ns / 1ps
// Reduction of a year modulo 400 by reciprocal multiplication and a registered subtract.
// Depends on gda_pkg.
module gda_mod400 import gda_pkg::*; #(
    parameter int YEAR_BITS = DEF_YEAR_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [YEAR_BITS-1:0] year,
    output logic                 done,
    output logic [CYC_BITS-1:0]  residue
);

    // The reciprocal is rounded up; with this shift the quotient is exact over the year range.
    localparam int SHIFT      = YEAR_BITS + CYC_BITS;
    localparam int RECIP_BITS = YEAR_BITS + 1;
    localparam int PROD_W     = YEAR_BITS + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] RECIP =
        RECIP_BITS'((longint'(1) << SHIFT) / CYCLE_YEARS + 1);
    localparam logic [YEAR_BITS-1:0] CYC_YB = YEAR_BITS'(CYCLE_YEARS);

    logic                 mul_reg, mul_next;
    logic                 sub_reg, sub_next;
    logic                 done_reg, done_next;
    logic [YEAR_BITS-1:0] yr_reg, yr_next;
    logic [YEAR_BITS-1:0] quo_reg, quo_next;
    logic [CYC_BITS-1:0]  rem_reg, rem_next;
    logic [PROD_W-1:0]    prod;
    logic [YEAR_BITS-1:0] diff;

    assign prod = PROD_W'(yr_reg) * PROD_W'(RECIP);
    assign diff = yr_reg - quo_reg * CYC_YB;

    always_comb
    begin
        mul_next  = start;
        sub_next  = mul_reg;
        done_next = sub_reg;
        yr_next   = yr_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start) begin
            yr_next = year;
        end
        if (mul_reg) begin
            quo_next = YEAR_BITS'(prod >> SHIFT);
        end
        if (sub_reg) begin
            rem_next = CYC_BITS'(diff);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mul_reg  <= 1'b0;
            sub_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else begin
            mul_reg  <= mul_next;
            sub_reg  <= sub_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        yr_reg  <= yr_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done    = done_reg;
    assign residue = rem_reg;

endmodule

>>> design/gregorian_date_add_days.sv
`timescale 1ns / 1ps
// The walk advances a whole month per cycle through one subtract-and-compare unit.
// The year residue modulo 400 is found first by a reciprocal multiplication.
// One beat is in flight at a time; the next is taken once the previous result is queued.
// Reset clears the sequencer and the output valid flag; no result is pending after it.
module gregorian_date_add_days import gda_pkg::*; #(
    parameter int OFFSET_BITS = DEF_OFFSET_BITS,
    parameter int YEAR_BITS   = DEF_YEAR_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  logic [DAY_BITS-1:0]    start_day,
    input  logic [MONTH_BITS-1:0]  start_month,
    input  logic [YEAR_BITS-1:0]   start_year,
    input  logic signed [OFFSET_BITS-1:0] offset_days,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output logic [DAY_BITS-1:0]    end_day,
    output logic [MONTH_BITS-1:0]  end_month,
    output logic [YEAR_BITS-1:0]   end_year,
    output logic [CNT_BITS-1:0]    short_febs,
    output logic [CNT_BITS-1:0]    long_febs,
    output logic                   year_overflow
);

    localparam logic [YEAR_BITS-1:0] YEAR_MAX = {YEAR_BITS{1'b1}};

    state_t state_reg, state_next;

    logic [DAY_BITS-1:0]    d_reg, d_next;
    logic [MONTH_BITS-1:0]  m_reg, m_next;
    logic [YEAR_BITS-1:0]   y_reg, y_next;
    logic [OFFSET_BITS-1:0] n_reg, n_next;
    logic                   back_reg, back_next;
    logic [CYC_BITS-1:0]    cyc_reg, cyc_next;
    logic [CNT_BITS-1:0]    sf_reg, sf_next;
    logic [CNT_BITS-1:0]    lf_reg, lf_next;
    logic                   ovf_reg, ovf_next;

    logic                   rsp_valid_reg, rsp_valid_next;
    logic [DAY_BITS-1:0]    od_reg, od_next;
    logic [MONTH_BITS-1:0]  om_reg, om_next;
    logic [YEAR_BITS-1:0]   oy_reg, oy_next;
    logic [CNT_BITS-1:0]    osf_reg, osf_next;
    logic [CNT_BITS-1:0]    olf_reg, olf_next;
    logic                   oovf_reg, oovf_next;

    logic                   req_fire;
    logic                   mod_done;
    logic [CYC_BITS-1:0]    mod_residue;
    logic                   leap;
    logic [DAY_BITS-1:0]    len;
    logic [DAY_BITS-1:0]    fwd_room;
    logic                   fits;
    logic                   at_edge;
    logic                   finish;
    logic                   load_out;
    logic [MONTH_BITS-1:0]  m_in;
    logic [DAY_BITS-1:0]    d_in;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign load_out  = (state_reg == ST_DONE) && (!rsp_valid_reg || rsp_ready);

    gda_mod400 #(
        .YEAR_BITS(YEAR_BITS)
    ) u_mod400 (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (req_fire),
        .year    (start_year),
        .done    (mod_done),
        .residue (mod_residue)
    );

    assign leap     = is_leap(cyc_reg);
    assign len      = month_len(m_reg, leap);
    assign fwd_room = len - d_reg;
    assign fits     = back_reg ? (n_reg < OFFSET_BITS'(d_reg))
                               : (n_reg <= OFFSET_BITS'(fwd_room));
    assign at_edge  = back_reg ? (m_reg == MON_JAN && y_reg == '0)
                               : (m_reg == MON_DEC && y_reg == YEAR_MAX);
    assign finish   = fits || at_edge;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire) begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (mod_done) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (finish) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_in = start_month;
        if (start_month < MON_JAN) begin
            m_in = MON_JAN;
        end
        else if (start_month > MON_DEC) begin
            m_in = MON_DEC;
        end
        d_in = (start_day == '0) ? DAY_FIRST : start_day;
    end

    always_comb
    begin
        d_next    = d_reg;
        m_next    = m_reg;
        y_next    = y_reg;
        n_next    = n_reg;
        back_next = back_reg;
        cyc_next  = cyc_reg;
        sf_next   = sf_reg;
        lf_next   = lf_reg;
        ovf_next  = ovf_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire) begin
                    d_next    = d_in;
                    m_next    = m_in;
                    y_next    = start_year;
                    back_next = offset_days[OFFSET_BITS-1];
                    n_next    = offset_days[OFFSET_BITS-1] ? (-offset_days) : offset_days;
                    sf_next   = '0;
                    lf_next   = '0;
                    ovf_next  = 1'b0;
                end
            end
            ST_MOD:
            begin
                if (mod_done) begin
                    cyc_next = mod_residue;
                end
            end
            ST_PREP:
            begin
                if (d_reg > len) begin
                    d_next = len;
                end
            end
            ST_WALK:
            begin
                if (!back_reg) begin
                    if (fits) begin
                        d_next = d_reg + n_reg[DAY_BITS-1:0];
                    end
                    else if (at_edge) begin
                        d_next   = len;
                        ovf_next = 1'b1;
                    end
                    else begin
                        n_next = n_reg - OFFSET_BITS'(fwd_room) - 1'b1;
                        d_next = DAY_FIRST;
                        if (m_reg == MON_FEB) begin
                            if (leap) begin
                                lf_next = (lf_reg == CNT_MAX) ? lf_reg : lf_reg + 1'b1;
                            end
                            else begin
                                sf_next = (sf_reg == CNT_MAX) ? sf_reg : sf_reg + 1'b1;
                            end
                        end
                        if (m_reg == MON_DEC) begin
                            m_next   = MON_JAN;
                            y_next   = y_reg + 1'b1;
                            cyc_next = (cyc_reg == CYC_LAST) ? '0 : cyc_reg + 1'b1;
                        end
                        else begin
                            m_next = m_reg + 1'b1;
                        end
                    end
                end
                else begin
                    if (fits) begin
                        d_next = d_reg - n_reg[DAY_BITS-1:0];
                    end
                    else if (at_edge) begin
                        d_next   = DAY_FIRST;
                        ovf_next = 1'b1;
                    end
                    else begin
                        n_next = n_reg - OFFSET_BITS'(d_reg);
                        if (m_reg == MON_JAN) begin
                            m_next   = MON_DEC;
                            d_next   = LEN_31;
                            y_next   = y_reg - 1'b1;
                            cyc_next = (cyc_reg == '0) ? CYC_LAST : cyc_reg - 1'b1;
                        end
                        else begin
                            m_next = m_reg - 1'b1;
                            d_next = month_len(m_reg - 1'b1, leap);
                        end
                        if (m_reg == MON_MAR) begin
                            if (leap) begin
                                lf_next = (lf_reg == CNT_MAX) ? lf_reg : lf_reg + 1'b1;
                            end
                            else begin
                                sf_next = (sf_reg == CNT_MAX) ? sf_reg : sf_reg + 1'b1;
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        od_next        = od_reg;
        om_next        = om_reg;
        oy_next        = oy_reg;
        osf_next       = osf_reg;
        olf_next       = olf_reg;
        oovf_next      = oovf_reg;
        if (load_out) begin
            rsp_valid_next = 1'b1;
            od_next        = d_reg;
            om_next        = m_reg;
            oy_next        = y_reg;
            osf_next       = sf_reg;
            olf_next       = lf_reg;
            oovf_next      = ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg    <= d_next;
        m_reg    <= m_next;
        y_reg    <= y_next;
        n_reg    <= n_next;
        back_reg <= back_next;
        cyc_reg  <= cyc_next;
        sf_reg   <= sf_next;
        lf_reg   <= lf_next;
        ovf_reg  <= ovf_next;
        od_reg   <= od_next;
        om_reg   <= om_next;
        oy_reg   <= oy_next;
        osf_reg  <= osf_next;
        olf_reg  <= olf_next;
        oovf_reg <= oovf_next;
    end

    assign rsp_valid     = rsp_valid_reg;
    assign end_day       = od_reg;
    assign end_month     = om_reg;
    assign end_year      = oy_reg;
    assign short_febs    = osf_reg;
    assign long_febs     = olf_reg;
    assign year_overflow = oovf_reg;

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("Result beat raised outside the completion state.");

    a_walk_month: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (m_reg >= MON_JAN && m_reg <= MON_DEC))
        else $error("Month left its range during the walk.");

    a_walk_day: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (d_reg >= DAY_FIRST && d_reg <= len))
        else $error("Day left its month during the walk.");

    a_walk_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (cyc_reg <= CYC_LAST))
        else $error("Year residue out of range.");

    a_ovf_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && oovf_reg) |->
            ((om_reg == MON_DEC && od_reg == LEN_31 && oy_reg == YEAR_MAX) ||
             (om_reg == MON_JAN && od_reg == DAY_FIRST && oy_reg == '0)))
        else $error("Overflow flagged away from the year range edge.");

endmodule

>>> bench/gregorian_date_add_days_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for gregorian_date_add_days: random and directed date requests,
// each result beat checked against a calendar walk computed here. Depends on gda_pkg.
module gregorian_date_add_days_tb import gda_pkg::*;;

    localparam int OFFSET_BITS = DEF_OFFSET_BITS;
    localparam int YEAR_BITS   = DEF_YEAR_BITS;
    localparam int YEAR_TOP    = (1 << YEAR_BITS) - 1;
    localparam int RANDOM_REQS = 100;
    localparam int LONG_HOLD   = 400;
    localparam int LONG_IDLE   = 60;

    localparam logic signed [OFFSET_BITS-1:0] OFF_MAX = {1'b0, {(OFFSET_BITS-1){1'b1}}};
    localparam logic signed [OFFSET_BITS-1:0] OFF_MIN = {1'b1, {(OFFSET_BITS-1){1'b0}}};

    typedef struct {
        logic [DAY_BITS-1:0]           day;
        logic [MONTH_BITS-1:0]         month;
        logic [YEAR_BITS-1:0]          year;
        logic signed [OFFSET_BITS-1:0] offset;
        int unsigned                   gap;
        bit                            drain;
    } date_req_t;

    typedef struct {
        logic [DAY_BITS-1:0]   day;
        logic [MONTH_BITS-1:0] month;
        logic [YEAR_BITS-1:0]  year;
        logic [CNT_BITS-1:0]   shorts;
        logic [CNT_BITS-1:0]   longs;
        logic                  ovf;
    } date_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          req_valid = 1'b0;
    logic                          req_ready;
    logic [DAY_BITS-1:0]           start_day = '0;
    logic [MONTH_BITS-1:0]         start_month = '0;
    logic [YEAR_BITS-1:0]          start_year = '0;
    logic signed [OFFSET_BITS-1:0] offset_days = '0;
    logic                          rsp_valid;
    logic                          rsp_ready = 1'b0;
    logic [DAY_BITS-1:0]           end_day;
    logic [MONTH_BITS-1:0]         end_month;
    logic [YEAR_BITS-1:0]          end_year;
    logic [CNT_BITS-1:0]           short_febs;
    logic [CNT_BITS-1:0]           long_febs;
    logic                          year_overflow;

    date_req_t    pending_dates[$];
    date_result_t expected_dates[$];
    int           queued_reqs = 0;
    int           accepted_reqs = 0;
    int           checked_rsps = 0;
    int           failures = 0;
    int unsigned  idle_cycles = 0;
    int unsigned  rsp_stall = 0;
    logic         hold_results = 1'b0;
    bit           no_gaps = 1'b0;
    bit           drain_next = 1'b0;
    longint       cycle_count = 0;
    longint       cycle_limit = longint'(10000 + LONG_HOLD);

    gregorian_date_add_days #(
        .OFFSET_BITS(OFFSET_BITS),
        .YEAR_BITS  (YEAR_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .start_day    (start_day),
        .start_month  (start_month),
        .start_year   (start_year),
        .offset_days  (offset_days),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .end_day      (end_day),
        .end_month    (end_month),
        .end_year     (end_year),
        .short_febs   (short_febs),
        .long_febs    (long_febs),
        .year_overflow(year_overflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit leap_year(input int unsigned y);
        if (y % 100 == 0)
        begin
            return (y % 400) == 0;
        end
        return (y % 4) == 0;
    endfunction

    function automatic int unsigned days_in(input int unsigned m, input int unsigned y);
        if (m == MON_FEB)
        begin
            return leap_year(y) ? 32'(LEN_LEAP) : 32'(LEN_SHORT);
        end
        if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV)
        begin
            return 32'(LEN_30);
        end
        return 32'(LEN_31);
    endfunction

    function automatic void tally_feb(input int unsigned len, inout int unsigned shorts,
                                      inout int unsigned longs);
        if (len == LEN_LEAP)
        begin
            if (longs < CNT_MAX)
                longs++;
        end
        else if (shorts < CNT_MAX)
        begin
            shorts++;
        end
    endfunction

    // The walk skips to the end of each month in one step; a February is counted as it is
    // left going forward, or entered from the first of March going backward.
    function automatic date_result_t walk_calendar(input logic [DAY_BITS-1:0] day_in,
                                                   input logic [MONTH_BITS-1:0] month_in,
                                                   input logic [YEAR_BITS-1:0] year_in,
                                                   input logic signed [OFFSET_BITS-1:0] offset_in);
        int unsigned  d, m, y, len, shorts, longs;
        longint       left;
        bit           back, ovf, done;
        date_result_t res;
        d = 32'(day_in);
        m = 32'(month_in);
        y = 32'(year_in);
        back = offset_in < 0;
        left = back ? -longint'(offset_in) : longint'(offset_in);
        shorts = 0;
        longs = 0;
        ovf = 1'b0;
        done = 1'b0;
        if (m < MON_JAN)
            m = 32'(MON_JAN);
        if (m > MON_DEC)
            m = 32'(MON_DEC);
        if (d < DAY_FIRST)
            d = 32'(DAY_FIRST);
        if (d > days_in(m, y))
            d = days_in(m, y);
        while (left > 0 && !done)
        begin
            if (!back)
            begin
                len = days_in(m, y);
                if (left <= len - d)
                begin
                    d += 32'(left);
                    done = 1'b1;
                end
                else
                begin
                    left -= longint'(len - d);
                    if (m == MON_DEC && y == YEAR_TOP)
                    begin
                        d = len;
                        ovf = 1'b1;
                        done = 1'b1;
                    end
                    else
                    begin
                        if (m == MON_FEB)
                            tally_feb(len, shorts, longs);
                        if (m == MON_DEC)
                        begin
                            m = 32'(MON_JAN);
                            y++;
                        end
                        else
                        begin
                            m++;
                        end
                        d = 32'(DAY_FIRST);
                        left--;
                    end
                end
            end
            else
            begin
                if (left <= d - 1)
                begin
                    d -= 32'(left);
                    done = 1'b1;
                end
                else
                begin
                    left -= longint'(d - 1);
                    d = 32'(DAY_FIRST);
                    if (m == MON_JAN && y == 0)
                    begin
                        ovf = 1'b1;
                        done = 1'b1;
                    end
                    else
                    begin
                        if (m == MON_JAN)
                        begin
                            m = 32'(MON_DEC);
                            y--;
                        end
                        else
                        begin
                            m--;
                        end
                        d = days_in(m, y);
                        if (m == MON_FEB)
                            tally_feb(d, shorts, longs);
                        left--;
                    end
                end
            end
        end
        res.day = DAY_BITS'(d);
        res.month = MONTH_BITS'(m);
        res.year = YEAR_BITS'(y);
        res.shorts = CNT_BITS'(shorts);
        res.longs = CNT_BITS'(longs);
        res.ovf = ovf;
        return res;
    endfunction

    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, LONG_IDLE);
    endfunction

    task automatic queue_date(input logic [DAY_BITS-1:0] d, input logic [MONTH_BITS-1:0] m,
                              input logic [YEAR_BITS-1:0] y,
                              input logic signed [OFFSET_BITS-1:0] off);
        date_req_t item;
        longint    mag;
        item.day = d;
        item.month = m;
        item.year = y;
        item.offset = off;
        item.gap = (no_gaps || $urandom_range(0, 1) == 0) ? 0 : idle_length();
        item.drain = drain_next;
        drain_next = 1'b0;
        pending_dates.push_back(item);
        queued_reqs++;
        mag = (off < 0) ? -longint'(off) : longint'(off);
        cycle_limit += 4 * (mag / 28 + YEAR_BITS + 8 + item.gap + 2 * LONG_IDLE);
    endtask

    task automatic queue_random_date();
        logic [DAY_BITS-1:0]           d;
        logic [MONTH_BITS-1:0]         m;
        logic [YEAR_BITS-1:0]          y;
        logic signed [OFFSET_BITS-1:0] off;
        int unsigned                   r;
        d = ($urandom_range(0, 4) == 0) ? DAY_BITS'($urandom_range(28, 31))
                                        : DAY_BITS'($urandom_range(0, 31));
        m = ($urandom_range(0, 9) == 0) ? MONTH_BITS'($urandom_range(0, 15))
                                        : MONTH_BITS'($urandom_range(1, 12));
        case ($urandom_range(0, 4))
            0, 1: y = YEAR_BITS'($urandom_range(0, YEAR_TOP));
            2: y = YEAR_BITS'($urandom_range(0, 3));
            3: y = YEAR_BITS'(YEAR_TOP - $urandom_range(0, 3));
            default: y = YEAR_BITS'(100 * $urandom_range(1, YEAR_TOP / 100) - 1 +
                                    $urandom_range(0, 2));
        endcase
        r = $urandom_range(0, 99);
        if (r < 88)
        begin
            off = (r < 70) ? OFFSET_BITS'($urandom_range(0, 400))
                           : OFFSET_BITS'($urandom_range(0, 40000));
            if ($urandom_range(0, 1) == 1)
                off = -off;
        end
        else if (r < 96)
        begin
            off = OFFSET_BITS'($urandom_range(0, (1 << OFFSET_BITS) - 1));
        end
        else
        begin
            off = ($urandom_range(0, 1) == 1) ? OFF_MAX - OFFSET_BITS'($urandom_range(0, 3))
                                              : OFF_MIN + OFFSET_BITS'($urandom_range(0, 3));
        end
        queue_date(d, m, y, off);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        date_req_t nxt;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                expected_dates.push_back(walk_calendar(start_day, start_month, start_year,
                                                       offset_days));
                accepted_reqs++;
            end
            if (!req_valid || req_ready)
            begin
                if (pending_dates.size() != 0 && idle_cycles < pending_dates[0].gap)
                begin
                    idle_cycles <= idle_cycles + 1;
                    req_valid <= 1'b0;
                end
                else if (pending_dates.size() != 0 &&
                         !(pending_dates[0].drain && expected_dates.size() != 0))
                begin
                    nxt = pending_dates.pop_front();
                    start_day <= nxt.day;
                    start_month <= nxt.month;
                    start_year <= nxt.year;
                    offset_days <= nxt.offset;
                    req_valid <= 1'b1;
                    idle_cycles <= 0;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : drive_rsp_ready
        int unsigned len;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            rsp_stall <= 0;
        end
        else if (hold_results)
        begin
            rsp_ready <= 1'b0;
        end
        else if (rsp_stall != 0)
        begin
            rsp_stall <= rsp_stall - 1;
            rsp_ready <= 1'b0;
        end
        else if (!(checked_rsps >= 80 && checked_rsps < 100) && $urandom_range(0, 7) == 0)
        begin
            len = idle_length();
            rsp_stall <= len - 1;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        date_result_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_dates.size() == 0)
            begin
                $error("result beat with no request outstanding");
                failures++;
            end
            else
            begin
                want = expected_dates.pop_front();
                checked_rsps++;
                if (end_day !== want.day)
                begin
                    $error("end_day: expected %0d, got %0d", want.day, end_day);
                    failures++;
                end
                if (end_month !== want.month)
                begin
                    $error("end_month: expected %0d, got %0d", want.month, end_month);
                    failures++;
                end
                if (end_year !== want.year)
                begin
                    $error("end_year: expected %0d, got %0d", want.year, end_year);
                    failures++;
                end
                if (short_febs !== want.shorts)
                begin
                    $error("short_febs: expected %0d, got %0d", want.shorts, short_febs);
                    failures++;
                end
                if (long_febs !== want.longs)
                begin
                    $error("long_febs: expected %0d, got %0d", want.longs, long_febs);
                    failures++;
                end
                if (year_overflow !== want.ovf)
                begin
                    $error("year_overflow: expected %0d, got %0d", want.ovf, year_overflow);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > cycle_limit)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Holding off the result side for a long stretch backs the block up until it
    // refuses new request beats.
    initial
    begin
        while (checked_rsps < 30)
            @(posedge clk);
        hold_results <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_results <= 1'b0;
    end

    initial
    begin
        queue_date(5'd15, MON_JUN, 14'd2024, OFFSET_BITS'(0));
        queue_date(5'd0, 4'd0, 14'd1999, OFFSET_BITS'(0));
        queue_date(5'd31, 4'd15, YEAR_BITS'(YEAR_TOP), OFFSET_BITS'(0));
        queue_date(5'd31, MON_FEB, 14'd2000, OFFSET_BITS'(0));
        queue_date(5'd30, MON_FEB, 14'd1900, OFFSET_BITS'(1));
        queue_date(5'd28, MON_FEB, 14'd2024, OFFSET_BITS'(1));
        queue_date(5'd28, MON_FEB, 14'd2024, OFFSET_BITS'(2));
        queue_date(5'd1, MON_MAR, 14'd2000, OFFSET_BITS'(-1));
        queue_date(5'd1, MON_MAR, 14'd2100, OFFSET_BITS'(-1));
        queue_date(5'd31, MON_APR, 14'd2023, OFFSET_BITS'(0));
        queue_date(5'd31, MON_DEC, YEAR_BITS'(YEAR_TOP), OFFSET_BITS'(1));
        queue_date(5'd1, MON_JAN, 14'd0, OFFSET_BITS'(-1));
        queue_date(5'd28, MON_FEB, 14'd0, OFFSET_BITS'(1));
        queue_date(5'd31, MON_DEC, 14'd1999, OFFSET_BITS'(1));
        queue_date(5'd1, MON_JAN, 14'd2000, OFFSET_BITS'(-1));
        queue_date(5'd1, MON_JAN, 14'd0, OFF_MAX);
        queue_date(5'd31, MON_DEC, YEAR_BITS'(YEAR_TOP), OFF_MIN);
        queue_date(5'd1, MON_JAN, YEAR_BITS'(YEAR_TOP - 3), OFF_MAX);
        queue_date(5'd1, MON_JAN, 14'd5, OFF_MIN);
        queue_date(5'd17, MON_SEP, 14'd1583, 21'h0AAAAA);
        queue_date(5'd9, MON_NOV, 14'd8000, 21'h155555);
        queue_date(5'd29, MON_FEB, 14'd400, OFFSET_BITS'(1461));
        queue_date(5'd15, MON_JUN, 14'd2000, OFFSET_BITS'(-1));
        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            if (i == 30)
                drain_next = 1'b1;
            no_gaps = (i >= 50 && i < 70);
            queue_random_date();
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        while (accepted_reqs < queued_reqs || checked_rsps < queued_reqs)
            @(posedge clk);
        repeat (YEAR_BITS + 8) @(posedge clk);
        if (expected_dates.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_dates.size());
            failures++;
        end
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
